FILE: sv/hid_boot_report_to_ascii_top_assert.svh
// Assertion macros shared by the RTL of the HID boot report converter.
// HBR_ASSERT is disabled while reset is low; HBR_ASSERT_NORST is checked always.
`ifndef HID_BOOT_REPORT_TO_ASCII_TOP_ASSERT_SVH
`define HID_BOOT_REPORT_TO_ASCII_TOP_ASSERT_SVH

`ifndef SYNTH

`define HBR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define HBR_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HBR_ASSERT(lbl, clk, rstn, prop, msg)

`define HBR_ASSERT_NORST(lbl, clk, prop, msg)

`endif

`endif

FILE: sv/hbr_pkg.sv
package hbr_pkg;

  localparam int MAX_KEY_SLOTS = 6;
  localparam int USAGE_W       = 8;
  localparam int CHAR_W        = 7;
  localparam int IN_DATA_W     = USAGE_W * (MAX_KEY_SLOTS + 1);
  localparam int OUT_DATA_W    = ((CHAR_W + 7) / 8) * 8;

  localparam logic [USAGE_W-1:0] SHIFT_MASK   = 8'h22;
  localparam logic [USAGE_W-1:0] CTRL_MASK    = 8'h11;

  // Usage codes of the boot keyboard page
  localparam logic [USAGE_W-1:0] USAGE_ERR_ROLL  = 8'h01;
  localparam logic [USAGE_W-1:0] USAGE_A         = 8'h04;
  localparam logic [USAGE_W-1:0] USAGE_Z         = 8'h1D;
  localparam logic [USAGE_W-1:0] USAGE_1         = 8'h1E;
  localparam logic [USAGE_W-1:0] USAGE_0         = 8'h27;
  localparam logic [USAGE_W-1:0] USAGE_ENTER     = 8'h28;
  localparam logic [USAGE_W-1:0] USAGE_ESCAPE    = 8'h29;
  localparam logic [USAGE_W-1:0] USAGE_BACKSPACE = 8'h2A;
  localparam logic [USAGE_W-1:0] USAGE_TAB       = 8'h2B;
  localparam logic [USAGE_W-1:0] USAGE_SPACE     = 8'h2C;
  localparam logic [USAGE_W-1:0] USAGE_MINUS     = 8'h2D;
  localparam logic [USAGE_W-1:0] USAGE_SLASH     = 8'h38;

  localparam logic [CHAR_W-1:0] ASCII_CR      = 7'h0D;
  localparam logic [CHAR_W-1:0] ASCII_ESC     = 7'h1B;
  localparam logic [CHAR_W-1:0] ASCII_BS      = 7'h08;
  localparam logic [CHAR_W-1:0] ASCII_HT      = 7'h09;
  localparam logic [CHAR_W-1:0] ASCII_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] ASCII_NONE    = 7'h00;

  // Shifted digit row, indexed by digit value
  function automatic logic [CHAR_W-1:0] shifted_digit(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    case (d)
      4'd0:    c = 7'h29;
      4'd1:    c = 7'h21;
      4'd2:    c = 7'h40;
      4'd3:    c = 7'h23;
      4'd4:    c = 7'h24;
      4'd5:    c = 7'h25;
      4'd6:    c = 7'h5E;
      4'd7:    c = 7'h26;
      4'd8:    c = 7'h2A;
      4'd9:    c = 7'h28;
      default: c = ASCII_NONE;
    endcase
    return c;
  endfunction

  // Punctuation from the minus key up to the slash key; the non-US hash key maps to nothing
  function automatic logic [CHAR_W-1:0] punct_char(input logic [3:0] idx, input logic shift);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd0:    c = shift ? 7'h5F : 7'h2D;
      4'd1:    c = shift ? 7'h2B : 7'h3D;
      4'd2:    c = shift ? 7'h7B : 7'h5B;
      4'd3:    c = shift ? 7'h7D : 7'h5D;
      4'd4:    c = shift ? 7'h7C : 7'h5C;
      4'd6:    c = shift ? 7'h3A : 7'h3B;
      4'd7:    c = shift ? 7'h22 : 7'h27;
      4'd8:    c = shift ? 7'h7E : 7'h60;
      4'd9:    c = shift ? 7'h3C : 7'h2C;
      4'd10:   c = shift ? 7'h3E : 7'h2E;
      4'd11:   c = shift ? 7'h3F : 7'h2F;
      default: c = ASCII_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] usage_to_ascii(input logic [USAGE_W-1:0] usage,
                                                       input logic [USAGE_W-1:0] mods);
    logic              shift;
    logic              ctrl;
    logic [USAGE_W-1:0] idx;
    logic [3:0]        d;
    logic [CHAR_W-1:0] c;
    shift = |(mods & SHIFT_MASK);
    ctrl  = |(mods & CTRL_MASK);
    idx   = usage - USAGE_A;
    d     = (usage == USAGE_0) ? 4'd0 : 4'(usage - USAGE_1 + 8'd1);
    c     = ASCII_NONE;
    if (usage >= USAGE_A && usage <= USAGE_Z) begin
      // control wins over shift
      c = ctrl ? CHAR_W'(idx + 8'd1)
               : CHAR_W'(idx) + (shift ? ASCII_UPPER_A : ASCII_LOWER_A);
    end else if (usage >= USAGE_1 && usage <= USAGE_0) begin
      c = shift ? shifted_digit(d) : ASCII_ZERO + CHAR_W'(d);
    end else if (usage >= USAGE_MINUS && usage <= USAGE_SLASH) begin
      c = punct_char(4'(usage - USAGE_MINUS), shift);
    end else begin
      case (usage)
        USAGE_ENTER:     c = ASCII_CR;
        USAGE_ESCAPE:    c = ASCII_ESC;
        USAGE_BACKSPACE: c = ASCII_BS;
        USAGE_TAB:       c = ASCII_HT;
        USAGE_SPACE:     c = ASCII_SPACE;
        default:         c = ASCII_NONE;
      endcase
    end
    return c;
  endfunction

endpackage

FILE: sv/hbr_decode.sv
module hbr_decode #(
  parameter int KEY_SLOTS = hbr_pkg::MAX_KEY_SLOTS
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic [hbr_pkg::IN_DATA_W-1:0]               in_data_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [KEY_SLOTS-1:0]                        out_mask_o,
  output logic [KEY_SLOTS-1:0][hbr_pkg::CHAR_W-1:0]   out_chars_o
);
  import hbr_pkg::*;

  logic                              rep_vld_q, rep_vld_d;
  logic [USAGE_W-1:0]                mods_q;
  logic [KEY_SLOTS-1:0][USAGE_W-1:0] slot_q;
  logic [KEY_SLOTS-1:0][USAGE_W-1:0] prev_q;
  logic                              accept;
  logic                              advance;
  logic [KEY_SLOTS-1:0]              held;

  assign advance    = rep_vld_q && out_ready_i;
  assign in_ready_o = !rep_vld_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign rep_vld_d  = accept ? 1'b1 : (advance ? 1'b0 : rep_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_vld_q <= 1'b0;
    end else begin
      rep_vld_q <= rep_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mods_q <= in_data_i[USAGE_W-1:0];
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slot_q[i] <= in_data_i[USAGE_W*(i+1) +: USAGE_W];
      end
    end
  end

  // Previous report: updated as the report leaves for the emitter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (advance) begin
      prev_q <= slot_q;
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      held[i] = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        held[i] = held[i] | (prev_q[j] == slot_q[i]);
      end
      out_chars_o[i] = usage_to_ascii(slot_q[i], mods_q);
      out_mask_o[i]  = (slot_q[i] > USAGE_ERR_ROLL) && !held[i]
                       && (out_chars_o[i] != ASCII_NONE);
    end
  end

  assign out_valid_o = rep_vld_q;

endmodule

FILE: sv/hbr_emit.sv
`include "hid_boot_report_to_ascii_top_assert.svh"

module hbr_emit #(
  parameter int KEY_SLOTS = hbr_pkg::MAX_KEY_SLOTS
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic [KEY_SLOTS-1:0]                        in_mask_i,
  input  logic [KEY_SLOTS-1:0][hbr_pkg::CHAR_W-1:0]   in_chars_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [hbr_pkg::CHAR_W-1:0]                  out_char_o,
  output logic                                        out_last_o
);
  import hbr_pkg::*;

  logic [KEY_SLOTS-1:0]              mask_q, mask_d;
  logic [KEY_SLOTS-1:0][CHAR_W-1:0]  chars_q;
  logic [KEY_SLOTS-1:0]              pick;
  logic [KEY_SLOTS-1:0]              rest;
  logic [CHAR_W-1:0]                 pick_char;
  logic                              emit;
  logic                              load;
  logic                              out_vld_q;
  logic [CHAR_W-1:0]                 out_char_q;
  logic                              out_last_q;

  // Lowest pending slot goes out first
  assign pick = mask_q & (~mask_q + KEY_SLOTS'(1));
  assign rest = mask_q & ~pick;

  always_comb begin
    pick_char = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      pick_char = pick_char | (pick[i] ? chars_q[i] : '0);
    end
  end

  assign emit       = (mask_q != '0) && (!out_vld_q || out_ready_i);
  assign in_ready_o = (mask_q == '0) || (emit && (rest == '0));
  assign load       = in_valid_i && in_ready_o;
  assign mask_d     = load ? in_mask_i : (emit ? rest : mask_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      chars_q <= in_chars_i;
    end
    if (emit) begin
      out_char_q <= pick_char;
      out_last_q <= (rest == '0);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  `HBR_ASSERT(a_mask_only_drains, clk_i, rst_ni, !load |=> (mask_q & ~$past(mask_q)) == '0, "mask grew")
  `HBR_ASSERT(a_load_when_empty, clk_i, rst_ni, load |-> in_ready_o, "report loaded over characters")
  `HBR_ASSERT(a_emit_fills_out, clk_i, rst_ni, emit |=> out_vld_q, "emitted character not held")
  `HBR_ASSERT_NORST(a_reset_empty, clk_i, !rst_ni |=> mask_q == '0 && !out_vld_q, "not empty in reset")

endmodule

FILE: sv/hid_boot_report_to_ascii_top.sv
// A report is held in the decode input register, then the char buffer, then the output register.
// Throughput: one character per cycle while m_axis_tready_i is high; a report holds the emitter
//   until its new characters (at most KEY_SLOTS) have drained through the single result channel.
// A report with no new character still passes through the char buffer and still updates the stored key slots.
// Reset (rst_ni low, asynchronous): stored previous key slots cleared to zero, all stages empty.
module hid_boot_report_to_ascii_top #(
  parameter int KEY_SLOTS = hbr_pkg::MAX_KEY_SLOTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] modifiers, [15:8] key_slot_0, [23:16] key_slot_1, [31:24] key_slot_2,
  // [39:32] key_slot_3, [47:40] key_slot_4, [55:48] key_slot_5
  input  logic [hbr_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [6:0] ascii_char, [7] zero
  output logic [hbr_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // last_of_report
  output logic                              m_axis_tlast_o
);
  import hbr_pkg::*;

  // Decoded report on its way to the emitter
  logic                             dec_valid;
  logic                             dec_ready;
  logic [KEY_SLOTS-1:0]             dec_mask;
  logic [KEY_SLOTS-1:0][CHAR_W-1:0] dec_chars;
  logic [CHAR_W-1:0]                out_char;

  // Input register, comparison with the previous report and usage mapping
  hbr_decode #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_mask_o  (dec_mask),
    .out_chars_o (dec_chars)
  );

  // Character buffer drained one item per cycle into the output register, unless the master side holds that register
  hbr_emit #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_mask_i   (dec_mask),
    .in_chars_i  (dec_chars),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o)
  );

  // Pad the character up to a whole byte
  assign m_axis_tdata_o = OUT_DATA_W'(out_char);

endmodule
